/* rtl/assert_macros.svh */
// Assertion macros shared by the tokeniser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is held.
`define STT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("tokeniser assertion failed");

// Same, with a message of the caller's choosing.
`define STT_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

`endif

/* rtl/stt_pkg.sv */
// Shared types, constants and character helpers of the source text tokeniser.
`timescale 1ns / 1ps

package stt_pkg;

    localparam int POS_BITS    = 24;
    localparam int LINE_BITS   = 20;
    localparam int OUT_POS_W   = 24;
    localparam int OUT_LINE_W  = 20;
    localparam int KIND_W      = 4;
    localparam int CHAR_W      = 8;
    localparam int OUT_DATA_W  = KIND_W + 2 * OUT_POS_W + OUT_LINE_W + CHAR_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
    localparam int IN_TDATA_W  = 8;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;

    typedef enum logic [KIND_W-1:0] {
        KIND_ASSIGN    = 4'd0,
        KIND_LPAREN    = 4'd1,
        KIND_RPAREN    = 4'd2,
        KIND_IDENT     = 4'd3,
        KIND_RETURN    = 4'd4,
        KIND_LET       = 4'd5,
        KIND_VAR       = 4'd6,
        KIND_INTEGER   = 4'd7,
        KIND_DECIMAL   = 4'd8,
        KIND_ILLEGAL   = 4'd9,
        KIND_UNCLOSED  = 4'd10
    } kind_t;

    // Bit positions in the keyword candidate mask.
    localparam int KW_RETURN = 0;
    localparam int KW_LET    = 1;
    localparam int KW_VAR    = 2;

    typedef struct packed {
        kind_t                 kind;
        logic [OUT_POS_W-1:0]  start;
        logic [OUT_POS_W-1:0]  len;
        logic [CHAR_W-1:0]     bad;
    } tok_t;

    // One queue entry holds everything a single byte produced.
    typedef struct packed {
        logic                  two;
        tok_t                  tok0;
        tok_t                  tok1;
        logic [OUT_LINE_W-1:0] line;
    } entry_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [CHAR_W-1:0] return_char(input logic [2:0] i);
        logic [CHAR_W-1:0] r;
        case (i)
            3'd0:    r = 8'h72;
            3'd1:    r = 8'h65;
            3'd2:    r = 8'h74;
            3'd3:    r = 8'h75;
            3'd4:    r = 8'h72;
            3'd5:    r = 8'h6E;
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] let_char(input logic [1:0] i);
        logic [CHAR_W-1:0] r;
        case (i)
            2'd0:    r = 8'h6C;
            2'd1:    r = 8'h65;
            2'd2:    r = 8'h74;
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] var_char(input logic [1:0] i);
        logic [CHAR_W-1:0] r;
        case (i)
            2'd0:    r = 8'h76;
            2'd1:    r = 8'h61;
            2'd2:    r = 8'h72;
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

    // Drops every keyword that the byte at offset idx of the word rules out.
    function automatic logic [2:0] kw_update(input logic [2:0] m, input logic [CHAR_W-1:0] c,
                                             input logic [POS_BITS-1:0] idx);
        logic [2:0] r;
        r = m;
        if (idx >= POS_BITS'(6) || return_char(idx[2:0]) != c) r[KW_RETURN] = 1'b0;
        if (idx >= POS_BITS'(3) || let_char(idx[1:0]) != c)    r[KW_LET]    = 1'b0;
        if (idx >= POS_BITS'(3) || var_char(idx[1:0]) != c)    r[KW_VAR]    = 1'b0;
        return r;
    endfunction

endpackage

/* rtl/stt_front.sv */
// Lexer front end: one byte a cycle unless stalled; forms the tokens it ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stt_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [stt_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  stt_pkg::q_status_t            q_status,
    output logic                          q_push,
    output stt_pkg::entry_t               q_entry
);
    import stt_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_DASH  = 3'd1,
        MODE_LINE  = 3'd2,
        MODE_BLOCK = 3'd3,
        MODE_IDENT = 3'd4,
        MODE_NUM   = 3'd5
    } mode_t;

    localparam logic [POS_BITS-1:0]  POS_MAX  = '1;
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    mode_t                mode_reg, mode_next;
    logic [POS_BITS-1:0]  byte_pos_reg, byte_pos_next;
    logic [LINE_BITS-1:0] line_count_reg, line_count_next;
    logic [POS_BITS-1:0]  token_start_reg, token_start_next;
    logic [2:0]           kw_reg, kw_next;
    logic                 seen_point_reg, seen_point_next;
    logic                 close_seen_reg, close_seen_next;
    logic                 done_reg, done_next;

    logic [CHAR_W-1:0]    ch;
    logic                 accept;
    logic                 end_src;
    logic                 used;
    logic                 line_inc;
    logic [POS_BITS-1:0]  diff;
    logic                 emit_a, emit_b;
    tok_t                 tok_a, tok_b;
    kind_t                ident_kind;

    assign ch       = s_tdata[CHAR_W-1:0];
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign end_src  = s_tlast || ch == CH_NUL;
    assign diff     = byte_pos_reg - token_start_reg;

    always_comb begin
        ident_kind = KIND_IDENT;
        if (diff == POS_BITS'(6) && kw_reg[KW_RETURN]) begin
            ident_kind = KIND_RETURN;
        end else if (diff == POS_BITS'(3) && kw_reg[KW_LET]) begin
            ident_kind = KIND_LET;
        end else if (diff == POS_BITS'(3) && kw_reg[KW_VAR]) begin
            ident_kind = KIND_VAR;
        end
    end

    always_comb begin
        mode_next        = mode_reg;
        token_start_next = token_start_reg;
        kw_next          = kw_reg;
        seen_point_next  = seen_point_reg;
        close_seen_next  = close_seen_reg;
        done_next        = done_reg;
        used             = 1'b0;
        line_inc         = 1'b0;
        emit_a           = 1'b0;
        emit_b           = 1'b0;
        tok_a            = '{kind: KIND_ASSIGN, start: '0, len: '0, bad: '0};
        tok_b            = '{kind: KIND_ASSIGN, start: '0, len: '0, bad: '0};

        // First the pending mode gets a chance to take the byte.
        case (mode_reg)
            MODE_DASH: begin
                if (!end_src && ch == CH_DASH) begin
                    mode_next = MODE_LINE;
                    used      = 1'b1;
                end else if (!end_src && ch == CH_LBRACK) begin
                    mode_next       = MODE_BLOCK;
                    close_seen_next = 1'b0;
                    used            = 1'b1;
                end else begin
                    emit_a    = 1'b1;
                    tok_a     = '{kind: KIND_ILLEGAL, start: OUT_POS_W'(token_start_reg),
                                  len: OUT_POS_W'(1), bad: CH_DASH};
                    mode_next = MODE_IDLE;
                end
            end
            MODE_LINE: begin
                if (!end_src) begin
                    used = 1'b1;
                    if (ch == CH_LF) begin
                        line_inc  = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_BLOCK: begin
                if (end_src) begin
                    emit_a = 1'b1;
                    tok_a  = '{kind: KIND_UNCLOSED, start: OUT_POS_W'(byte_pos_reg),
                               len: OUT_POS_W'(1), bad: '0};
                end else begin
                    used = 1'b1;
                    if (ch == CH_LF) begin
                        line_inc = 1'b1;
                    end
                    if (close_seen_reg && ch == CH_DASH) begin
                        mode_next = MODE_IDLE;
                    end
                    close_seen_next = (ch == CH_RBRACK);
                end
            end
            MODE_IDENT: begin
                if (!end_src && (is_alpha(ch) || is_digit(ch))) begin
                    kw_next = kw_update(kw_reg, ch, diff);
                    used    = 1'b1;
                end else begin
                    emit_a    = 1'b1;
                    tok_a     = '{kind: ident_kind, start: OUT_POS_W'(token_start_reg),
                                  len: OUT_POS_W'(diff), bad: '0};
                    mode_next = MODE_IDLE;
                end
            end
            MODE_NUM: begin
                if (!end_src && (is_digit(ch) || ch == CH_UNDER)) begin
                    used = 1'b1;
                end else if (!end_src && ch == CH_POINT && !seen_point_reg) begin
                    seen_point_next = 1'b1;
                    used            = 1'b1;
                end else begin
                    emit_a    = 1'b1;
                    tok_a     = '{kind: seen_point_reg ? KIND_DECIMAL : KIND_INTEGER,
                                  start: OUT_POS_W'(token_start_reg),
                                  len: OUT_POS_W'(diff), bad: '0};
                    mode_next = MODE_IDLE;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase

        // A byte that no pending token took is lexed afresh from idle.
        if (end_src) begin
            done_next = 1'b1;
            mode_next = MODE_IDLE;
        end else if (!used) begin
            used = 1'b1;
            if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR) begin
                mode_next = MODE_IDLE;
            end else if (ch == CH_LF) begin
                line_inc = 1'b1;
            end else if (ch == CH_DASH) begin
                mode_next        = MODE_DASH;
                token_start_next = byte_pos_reg;
            end else if (ch == CH_EQUALS || ch == CH_LPAREN || ch == CH_RPAREN) begin
                emit_b = 1'b1;
                tok_b  = '{kind: (ch == CH_EQUALS) ? KIND_ASSIGN :
                                 (ch == CH_LPAREN) ? KIND_LPAREN : KIND_RPAREN,
                           start: OUT_POS_W'(byte_pos_reg), len: OUT_POS_W'(1), bad: '0};
            end else if (is_alpha(ch)) begin
                mode_next        = MODE_IDENT;
                token_start_next = byte_pos_reg;
                kw_next          = kw_update(3'b111, ch, '0);
            end else if (is_digit(ch)) begin
                mode_next        = MODE_NUM;
                token_start_next = byte_pos_reg;
                seen_point_next  = 1'b0;
            end else begin
                emit_b = 1'b1;
                tok_b  = '{kind: KIND_ILLEGAL, start: OUT_POS_W'(byte_pos_reg),
                           len: OUT_POS_W'(1), bad: ch};
            end
        end

        byte_pos_next = byte_pos_reg;
        if (used && byte_pos_reg != POS_MAX) begin
            byte_pos_next = byte_pos_reg + POS_BITS'(1);
        end
        line_count_next = line_count_reg;
        if (line_inc && line_count_reg != LINE_MAX) begin
            line_count_next = line_count_reg + LINE_BITS'(1);
        end
    end

    always_comb begin
        q_push        = accept && !done_reg && (emit_a || emit_b);
        q_entry.two   = emit_a && emit_b;
        q_entry.tok0  = emit_a ? tok_a : tok_b;
        q_entry.tok1  = tok_b;
        q_entry.line  = OUT_LINE_W'(line_count_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            byte_pos_reg    <= '0;
            line_count_reg  <= '0;
            token_start_reg <= '0;
            kw_reg          <= 3'b111;
            seen_point_reg  <= 1'b0;
            close_seen_reg  <= 1'b0;
            done_reg        <= 1'b0;
        end else if (accept && !done_reg) begin
            mode_reg        <= mode_next;
            byte_pos_reg    <= byte_pos_next;
            line_count_reg  <= line_count_next;
            token_start_reg <= token_start_next;
            kw_reg          <= kw_next;
            seen_point_reg  <= seen_point_next;
            close_seen_reg  <= close_seen_next;
            done_reg        <= done_next;
        end
    end

    `STT_ASSERT(a_no_push_after_end, aclk, aresetn, done_reg |-> !q_push)
    `STT_ASSERT_MSG(a_end_sets_done, aclk, aresetn, (accept && end_src) |=> done_reg, "end of source not latched")
    `STT_ASSERT_MSG(a_no_push_when_full, aclk, aresetn, q_status.full |-> !q_push, "push into a full queue")

endmodule

/* rtl/stt_queue.sv */
// Short queue of per-byte token groups between the lexer and the output stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stt_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  stt_pkg::entry_t    push_entry,
    input  logic               pop,
    output stt_pkg::entry_t    head,
    output stt_pkg::q_status_t status
);
    import stt_pkg::*;

    entry_t            entries_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head             = entries_reg[rd_ptr_reg];
    assign status.not_empty = count_reg != '0;
    assign status.full      = count_reg == QCNT_W'(QDEPTH);

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `STT_ASSERT_MSG(a_no_pop_empty, aclk, aresetn, pop |-> status.not_empty, "pop from an empty queue")
    `STT_ASSERT(a_count_tracks_push, aclk, aresetn, (push && !pop) |=> count_reg == $past(count_reg) + QCNT_W'(1))

endmodule

/* rtl/stt_back.sv */
// Output stage: hands the queued tokens out one beat at a time.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stt_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  stt_pkg::entry_t                 head,
    input  stt_pkg::q_status_t              q_status,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stt_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);
    import stt_pkg::*;

    logic                  sel_reg, sel_next;
    logic                  valid_reg, valid_next;
    tok_t                  tok_reg, tok_next;
    logic [OUT_LINE_W-1:0] line_reg;
    logic                  last_reg, last_next;
    logic                  load;

    assign load = q_status.not_empty && (!valid_reg || m_tready);

    always_comb begin
        tok_next   = sel_reg ? head.tok1 : head.tok0;
        last_next  = !head.two || sel_reg;
        pop        = load && last_next;
        sel_next   = sel_reg;
        valid_next = valid_reg && !m_tready;
        if (load) begin
            sel_next   = !last_next;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg  <= tok_next;
            line_reg <= head.line;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = OUT_TDATA_W'({tok_reg.bad, line_reg, tok_reg.len, tok_reg.start,
                                    tok_reg.kind});

    `STT_ASSERT_MSG(a_second_follows, aclk, aresetn, (m_tvalid && m_tready && !m_tlast) |=> m_tvalid, "second token of a pair missing")
    `STT_ASSERT(a_pair_head_held, aclk, aresetn, sel_reg |-> (q_status.not_empty && head.two))

endmodule

/* rtl/source_text_tokenizer.sv */
// Top level of the source text tokeniser: lexer, token queue and output stage.
`timescale 1ns / 1ps

//  Channel   Side     Fields (tdata from bit 0 up)                          tlast
//  s_        input    ch[7:0]                                               is_end
//  m_        output   kind[3:0] start_pos[27:4] length[51:28] line[71:52]   last
//                     bad_char[79:72]
//
// The lexer takes one source byte in every cycle while s_tready is high; its mode register
// is updated from combinational logic, so a byte can follow in the very next cycle.
// Results leave at one beat per cycle from a registered output stage unless m_tready
// holds them; a byte that ends one token and is itself a token gives two beats, the
// second with tlast set. A four-entry queue between lexer and output stage absorbs such
// pairs and stalls on the output side; s_tready falls only while that queue is full.
// Reset is synchronous on aresetn, active low, and returns the lexer to the start of a
// new source. After an end marker or a zero byte every further beat is taken and dropped.

module source_text_tokenizer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [stt_pkg::IN_TDATA_W-1:0]  s_tdata,   // ch[7:0]
    input  logic                            s_tlast,   // end of source marker
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stt_pkg::OUT_TDATA_W-1:0] m_tdata,   // kind, start_pos, length, line,
                                                       // bad_char
    output logic                            m_tlast    // last result of this input beat
);
    import stt_pkg::*;

    q_status_t q_status;
    logic      q_push;
    logic      q_pop;
    entry_t    q_in;
    entry_t    q_head;

    // Front end: classifies every byte and forms up to two tokens from it.
    stt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    // Groups of tokens wait here so that each side can stall on its own.
    stt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    // Back end: splits each group into result beats.
    stt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .q_status (q_status),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
